### hdl/nslu_pkg.sv
// Shared types and constants for the nonsingular subset LU pivot block.
package nslu_pkg;

  // Fixed sizes of the block.
  localparam int MAX_P     = 16;
  localparam int PB        = 4;
  localparam int LA_W      = 2 * PB;
  localparam int L_DEPTH   = MAX_P * MAX_P;
  localparam int IDX_W     = 16;
  localparam int VAL_W     = 32;
  localparam int WORK_W    = 48;
  localparam int L_W       = 32;
  localparam int Q_W       = 31;
  localparam int PC_W      = 5;
  localparam int OBS_W     = 16;
  localparam int THR_W     = 31;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 5;

  localparam logic [PC_W-1:0]   P_MAX     = 5'd16;
  localparam logic [PC_W-1:0]   P_MIN     = 5'd1;
  localparam logic [STEP_W-1:0] DIV_LAST  = 5'd30;
  localparam logic [IDX_W-1:0]  SKIP_MAX  = 16'hFFFF;
  localparam logic [WORK_W-1:0] WORK_MAXV = 48'h7FFF_FFFF_FFFF;
  localparam logic [WORK_W-1:0] WORK_MINV = 48'h8000_0000_0000;

  // Reset values of the configuration registers.
  localparam logic [PC_W-1:0]  PC_RESET  = 5'd4;
  localparam logic [OBS_W-1:0] OBS_RESET = 16'hFFFF;
  localparam logic [THR_W-1:0] THR_RESET = 31'd1;

  // Operation codes of an input item.
  localparam logic OP_ELEMENT = 1'b0;
  localparam logic OP_END     = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PARAM_COUNT = 2'd0,
    CFG_OBS_COUNT   = 2'd1,
    CFG_THRESHOLD   = 2'd2
  } cfg_idx_t;

  // Kinds of result that the controller asks for.
  typedef enum logic [2:0] {
    EM_END   = 3'd0,
    EM_FAULT = 3'd1,
    EM_FULL  = 3'd2,
    EM_ACC   = 3'd3,
    EM_SKIP  = 3'd4
  } emit_kind_t;

  typedef struct packed {
    logic                    operation;
    logic [IDX_W-1:0]        column_index;
    logic signed [VAL_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] candidate_column;
    logic             accepted;
    logic [PC_W-1:0]  rank;
    logic [IDX_W-1:0] skipped_count;
    logic             finished;
    logic             singular;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take;
    logic       load_s;
    logic       mac_rd;
    logic       mac_mul;
    logic       mac_acc;
    logic       store;
    logic       swap_rd;
    logic       swap_wr;
    logic       ls_rj;
    logic       ls_rm;
    logic       ls_wj;
    logic       ls_wm;
    logic       dv_load;
    logic       dv_step;
    logic       dv_first;
    logic       dv_wr;
    logic       emit;
    emit_kind_t kind;
    logic [PB-1:0] i;
    logic [PB-1:0] t;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic            in_end;
    logic            col_done;
    logic            fault;
    logic            full_rank;
    logic [PC_W-1:0] rank;
    logic [PC_W-1:0] p;
    logic            piv_ok;
    logic            mu_ne_j;
    logic            out_free;
  } dp_sts_t;

endpackage

### hdl/nslu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nslu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/nslu_ctrl.sv
// Controller state machine that sequences substitution, pivoting and division.
module nslu_ctrl import nslu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [17:0] {
    S_IDLE  = 18'd1,
    S_LOAD  = 18'd2,
    S_MRD   = 18'd4,
    S_MMUL  = 18'd8,
    S_MACC  = 18'd16,
    S_STORE = 18'd32,
    S_JUDGE = 18'd64,
    S_SW1   = 18'd128,
    S_SW2   = 18'd256,
    S_LRJ   = 18'd512,
    S_LRM   = 18'd1024,
    S_LWJ   = 18'd2048,
    S_LWM   = 18'd4096,
    S_DVST  = 18'd8192,
    S_DVL   = 18'd16384,
    S_DVS   = 18'd32768,
    S_DVW   = 18'd65536,
    S_EMIT  = 18'd131072
  } state_t;

  state_t            state_r, state_nxt;
  logic [PC_W-1:0]   i_r, i_nxt;
  logic [PB-1:0]     t_r, t_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  emit_kind_t        kind_r, kind_nxt;
  logic [PC_W-1:0]   lim;
  logic [PC_W-1:0]   t_inc;
  logic [PC_W-1:0]   i_inc;
  logic              accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign lim      = (i_r < sts.rank) ? i_r : sts.rank;
  assign t_inc    = {1'b0, t_r} + 5'd1;
  assign i_inc    = i_r + 5'd1;

  // State and loop counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      t_r     <= '0;
      step_r  <= '0;
      kind_r  <= EM_END;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      t_r     <= t_nxt;
      step_r  <= step_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    t_nxt     = t_r;
    step_nxt  = step_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    cmd.i     = i_r[PB-1:0];
    cmd.t     = t_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.take = accept;
        if (accept) begin
          i_nxt = '0;
          if (sts.in_end) begin
            kind_nxt  = EM_END;
            state_nxt = S_EMIT;
          end else if (sts.col_done) begin
            if (sts.fault) begin
              kind_nxt  = EM_FAULT;
              state_nxt = S_EMIT;
            end else if (sts.full_rank) begin
              kind_nxt  = EM_FULL;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_LOAD;
            end
          end
        end
      end
      S_LOAD: begin
        cmd.load_s = 1'b1;
        t_nxt      = '0;
        state_nxt  = (lim == '0) ? S_STORE : S_MRD;
      end
      S_MRD: begin
        cmd.mac_rd = 1'b1;
        state_nxt  = S_MMUL;
      end
      S_MMUL: begin
        cmd.mac_mul = 1'b1;
        state_nxt   = S_MACC;
      end
      S_MACC: begin
        cmd.mac_acc = 1'b1;
        if (t_inc == lim) begin
          state_nxt = S_STORE;
        end else begin
          t_nxt     = t_inc[PB-1:0];
          state_nxt = S_MRD;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (i_inc == sts.p) begin
          state_nxt = S_JUDGE;
        end else begin
          i_nxt     = i_inc;
          state_nxt = S_LOAD;
        end
      end
      S_JUDGE: begin
        if (!sts.piv_ok) begin
          kind_nxt  = EM_SKIP;
          state_nxt = S_EMIT;
        end else if (sts.mu_ne_j) begin
          state_nxt = S_SW1;
        end else begin
          state_nxt = S_DVST;
        end
      end
      S_SW1: begin
        cmd.swap_rd = 1'b1;
        state_nxt   = S_SW2;
      end
      S_SW2: begin
        cmd.swap_wr = 1'b1;
        t_nxt       = '0;
        state_nxt   = (sts.rank != '0) ? S_LRJ : S_DVST;
      end
      // Swap of the already filled factor columns of rows j and mu.
      S_LRJ: begin
        cmd.ls_rj = 1'b1;
        state_nxt = S_LRM;
      end
      S_LRM: begin
        cmd.ls_rm = 1'b1;
        state_nxt = S_LWJ;
      end
      S_LWJ: begin
        cmd.ls_wj = 1'b1;
        state_nxt = S_LWM;
      end
      S_LWM: begin
        cmd.ls_wm = 1'b1;
        if (t_inc == sts.rank) begin
          state_nxt = S_DVST;
        end else begin
          t_nxt     = t_inc[PB-1:0];
          state_nxt = S_LRJ;
        end
      end
      S_DVST: begin
        i_nxt = sts.rank + 5'd1;
        if ((sts.rank + 5'd1) >= sts.p) begin
          kind_nxt  = EM_ACC;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DVL;
        end
      end
      S_DVL: begin
        cmd.dv_load = 1'b1;
        step_nxt    = '0;
        state_nxt   = S_DVS;
      end
      S_DVS: begin
        cmd.dv_step  = 1'b1;
        cmd.dv_first = (step_r == '0);
        if (step_r == DIV_LAST) begin
          state_nxt = S_DVW;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      S_DVW: begin
        cmd.dv_wr = 1'b1;
        if (i_inc >= sts.p) begin
          kind_nxt  = EM_ACC;
          state_nxt = S_EMIT;
        end else begin
          i_nxt     = i_inc;
          state_nxt = S_DVL;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/nslu_dp.sv
// Datapath: configuration, buffers, factor memory, multiply-accumulate and divider.
module nslu_dp import nslu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  in_item_t             in_data,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output out_item_t            out_data,
  output logic                 out_valid,
  input  logic                 out_stall
);

  // Configuration.
  logic [PC_W-1:0]  pc_r;
  logic [OBS_W-1:0] obs_r;
  logic [THR_W-1:0] thr_r;
  logic [PC_W-1:0]  p_eff;

  // Walk state and buffers.
  logic signed [VAL_W-1:0]  cbuf_r [MAX_P];
  logic signed [WORK_W-1:0] work_r [MAX_P];
  logic [PB-1:0]            row_r  [MAX_P];
  logic [L_DEPTH-1:0]       lval_r;
  logic [PC_W-1:0]          rank_r;
  logic [PB-1:0]            cnt_r;
  logic [IDX_W-1:0]         skip_r;
  logic                     fault_r;
  logic [IDX_W-1:0]         cand_r;

  // Arithmetic registers.
  logic signed [WORK_W-1:0] s_r, z_r, bval_r, tmpw_r;
  logic [WORK_W-1:0]        best_r, ud_r;
  logic [PB-1:0]            mu_r, tmpr_r;
  logic signed [L_W-1:0]    tmpl_r;
  logic                     tmpv_r, lv_r, neg_r, dz_r;
  logic signed [63:0]       a_r;
  logic signed [48:0]       b_r;
  logic [WORK_W:0]          r_r;
  logic [Q_W-1:0]           q_r;

  // Output register.
  out_item_t out_r;
  logic      out_valid_r;

  logic [PB-1:0]            j;
  logic [PB-1:0]            wv_addr, ro_addr;
  logic signed [WORK_W-1:0] wv_rd;
  logic [PB-1:0]            row_rd;
  logic [LA_W-1:0]          ram_raddr, ram_waddr;
  logic [L_W-1:0]           ram_wdata, ram_rdata;
  logic                     ram_we, ram_wval;
  logic signed [L_W-1:0]    l_eff;
  logic signed [79:0]       tot;
  logic [49:0]              prod;
  logic signed [50:0]       diff;
  logic signed [WORK_W-1:0] s_sat;
  logic [WORK_W-1:0]        s_mag;
  logic [WORK_W:0]          r_sh;
  logic                     r_ge;
  logic [L_W-1:0]           q_mag, q_out;
  logic [PC_W-1:0]          cnt_inc;
  logic                     idx_bad;
  logic [PC_W-1:0]          rank_inc;
  logic [IDX_W-1:0]         skip_inc;
  out_item_t                emit_item;
  logic                     emit_clear;

  function automatic logic [WORK_W-1:0] abs_w(input logic signed [WORK_W-1:0] v);
    abs_w = v[WORK_W-1] ? (~v + 48'd1) : v;
  endfunction

  // Parameter count clamped to its legal range.
  always_comb begin
    if (pc_r == '0) begin
      p_eff = P_MIN;
    end else if (pc_r > P_MAX) begin
      p_eff = P_MAX;
    end else begin
      p_eff = pc_r;
    end
  end

  assign j        = rank_r[PB-1:0];
  assign cnt_inc  = {1'b0, cnt_r} + 5'd1;
  assign idx_bad  = (in_data.column_index >= obs_r);
  assign rank_inc = rank_r + 5'd1;
  assign skip_inc = (skip_r == SKIP_MAX) ? skip_r : skip_r + 16'd1;

  // Single read port of the work vector and of the row order.
  always_comb begin
    wv_addr = cmd.i;
    if (cmd.mac_rd) begin
      wv_addr = cmd.t;
    end else if (cmd.swap_rd) begin
      wv_addr = mu_r;
    end else if (cmd.swap_wr) begin
      wv_addr = j;
    end
    ro_addr = cmd.i;
    if (cmd.swap_rd) begin
      ro_addr = mu_r;
    end else if (cmd.swap_wr) begin
      ro_addr = j;
    end
  end

  assign wv_rd  = work_r[wv_addr];
  assign row_rd = row_r[ro_addr];

  // Factor memory addressing.
  always_comb begin
    ram_raddr = {cmd.i, cmd.t};
    if (cmd.ls_rj) begin
      ram_raddr = {j, cmd.t};
    end else if (cmd.ls_rm) begin
      ram_raddr = {mu_r, cmd.t};
    end
    ram_we    = cmd.ls_wj || cmd.ls_wm || cmd.dv_wr;
    ram_waddr = {cmd.i, j};
    ram_wdata = q_out;
    ram_wval  = 1'b1;
    if (cmd.ls_wj) begin
      ram_waddr = {j, cmd.t};
      ram_wdata = ram_rdata;
      ram_wval  = lv_r;
    end else if (cmd.ls_wm) begin
      ram_waddr = {mu_r, cmd.t};
      ram_wdata = tmpl_r;
      ram_wval  = tmpv_r;
    end
  end

  nslu_ram #(
    .WIDTH(L_W),
    .DEPTH(L_DEPTH)
  ) u_lram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Multiply-accumulate: floor(l * z / 2^30) subtracted with saturation.
  assign l_eff = lv_r ? $signed(ram_rdata) : '0;
  assign tot   = $signed({a_r, 16'h0000}) + $signed({{31{b_r[48]}}, b_r});
  assign prod  = tot[79:30];
  assign diff  = $signed({{3{s_r[WORK_W-1]}}, s_r}) - $signed({prod[49], prod});
  always_comb begin
    if (diff[50:47] == 4'b0000 || diff[50:47] == 4'b1111) begin
      s_sat = diff[WORK_W-1:0];
    end else if (diff[50]) begin
      s_sat = WORK_MINV;
    end else begin
      s_sat = WORK_MAXV;
    end
  end
  assign s_mag = abs_w(s_r);

  // Restoring divider step, one quotient bit per cycle.
  assign r_sh  = cmd.dv_first ? r_r : {r_r[WORK_W-1:0], 1'b0};
  assign r_ge  = (r_sh >= {1'b0, ud_r});
  assign q_mag = {1'b0, q_r};
  assign q_out = dz_r ? '0 : (neg_r ? (~q_mag + 32'd1) : q_mag);

  // Result fields for each kind of result.
  always_comb begin
    emit_item                  = '0;
    emit_item.candidate_column = cand_r;
    emit_item.rank             = rank_r;
    emit_item.skipped_count    = skip_r;
    emit_clear                 = 1'b1;
    case (cmd.kind)
      EM_END: begin
        emit_item.candidate_column = '0;
        emit_item.finished         = 1'b1;
        emit_item.singular         = (rank_r < p_eff);
      end
      EM_FAULT: begin
        emit_item.finished = 1'b1;
        emit_item.singular = 1'b1;
      end
      EM_FULL: begin
        emit_item.finished = 1'b1;
      end
      EM_ACC: begin
        emit_item.accepted = 1'b1;
        emit_item.rank     = rank_inc;
        emit_item.finished = (rank_inc >= p_eff);
        emit_clear         = (rank_inc >= p_eff);
      end
      EM_SKIP: begin
        emit_item.skipped_count = skip_inc;
        emit_clear              = 1'b0;
      end
      default: begin
        emit_clear = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= PC_RESET;
      obs_r <= OBS_RESET;
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PARAM_COUNT: pc_r  <= cfg_wdata[PC_W-1:0];
        CFG_OBS_COUNT:   obs_r <= cfg_wdata[OBS_W-1:0];
        CFG_THRESHOLD:   thr_r <= cfg_wdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Walk control state: rank, counters, row order and factor valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.emit && emit_clear)) begin
      rank_r  <= '0;
      cnt_r   <= '0;
      skip_r  <= '0;
      fault_r <= 1'b0;
      lval_r  <= '0;
      for (int k = 0; k < MAX_P; k++) begin
        row_r[k] <= PB'(k);
      end
    end else begin
      if (cmd.take && in_data.operation == OP_ELEMENT) begin
        fault_r <= fault_r || idx_bad;
        cnt_r   <= (cnt_inc >= p_eff) ? '0 : cnt_inc[PB-1:0];
      end
      if (cmd.emit && cmd.kind == EM_ACC) begin
        rank_r <= rank_inc;
      end
      if (cmd.emit && cmd.kind == EM_SKIP) begin
        skip_r <= skip_inc;
      end
      if (cmd.swap_wr) begin
        row_r[mu_r] <= row_rd;
        row_r[j]    <= tmpr_r;
      end
      if (ram_we) begin
        lval_r[ram_waddr] <= ram_wval;
      end
    end
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk) begin
    lv_r <= lval_r[ram_raddr];
    if (cmd.take && in_data.operation == OP_ELEMENT) begin
      cbuf_r[cnt_r] <= in_data.element_value;
      cand_r        <= in_data.column_index;
    end
    if (cmd.load_s) begin
      s_r <= WORK_W'(cbuf_r[row_rd]);
    end
    if (cmd.mac_rd) begin
      z_r <= wv_rd;
    end
    if (cmd.mac_mul) begin
      a_r <= l_eff * $signed(z_r[WORK_W-1:16]);
      b_r <= l_eff * $signed({1'b0, z_r[15:0]});
    end
    if (cmd.mac_acc) begin
      s_r <= s_sat;
    end
    if (cmd.store) begin
      work_r[cmd.i] <= s_r;
      if (cmd.i == j || (cmd.i > j && s_mag > best_r)) begin
        best_r <= s_mag;
        bval_r <= s_r;
        mu_r   <= cmd.i;
      end
    end
    if (cmd.swap_rd) begin
      tmpw_r <= wv_rd;
      tmpr_r <= row_rd;
    end
    if (cmd.swap_wr) begin
      work_r[mu_r] <= wv_rd;
      work_r[j]    <= tmpw_r;
    end
    if (cmd.ls_rm) begin
      tmpl_r <= $signed(ram_rdata);
      tmpv_r <= lv_r;
    end
    if (cmd.dv_load) begin
      r_r   <= {1'b0, abs_w(wv_rd)};
      ud_r  <= abs_w(bval_r);
      q_r   <= '0;
      neg_r <= wv_rd[WORK_W-1] ^ bval_r[WORK_W-1];
      dz_r  <= (bval_r == '0);
    end
    if (cmd.dv_step) begin
      r_r <= r_ge ? (r_sh - {1'b0, ud_r}) : r_sh;
      q_r <= {q_r[Q_W-2:0], r_ge};
    end
  end

  // Output register; it frees as soon as the receiver takes the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= emit_item;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  // Status toward the controller.
  always_comb begin
    sts           = '0;
    sts.in_end    = (in_data.operation == OP_END);
    sts.col_done  = (cnt_inc >= p_eff);
    sts.fault     = fault_r || idx_bad;
    sts.full_rank = (rank_r >= p_eff);
    sts.rank      = rank_r;
    sts.p         = p_eff;
    sts.piv_ok    = (best_r >= {17'd0, thr_r});
    sts.mu_ne_j   = (mu_r != j);
    sts.out_free  = !out_valid_r || !out_stall;
  end

endmodule

### hdl/nonsingular_subset_lu_pivot.sv
// Top level of the nonsingular subset LU pivot block.
//
// Input items carry one element of a candidate column each (rows in original
// order) or an end-of-walk mark. Each column of p elements is judged against
// the stored unit lower factor and row permutation: forward substitution, a
// partial pivot search, then either a skip or an acceptance with row swap and
// new factor column. Every judged column and every end of walk gives one
// result item; the other elements give none.
// An element that does not complete a column is taken without a stall. A
// completed column runs forward substitution (one shared multiply-accumulate
// unit with a read, a multiply and an accumulate step per product), the pivot
// decision, a row swap when the pivot row moves, a step on acceptance before
// the division, the bit-serial divider for each new factor entry, and the
// load of the result. The input stalls for that whole span; the next item is
// taken after the result is loaded, even while that result still waits at
// the output.
// A result item holds in the output register while out_stall is high; the
// block does not finish a later column until the register frees.
// Reset (rst_n low at a clock edge) restores the configuration defaults, an
// identity row order, an empty factor and a zero rank and skip count.
// Configuration writes take effect on the next item.
module nonsingular_subset_lu_pivot import nslu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  nslu_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Arithmetic and storage.
  nslu_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

endmodule

### hdl/nslu_chk.sv
// Port-level checker for the nonsingular subset LU pivot block, with its bind.
module nslu_chk import nslu_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_wdata,
  input logic                 in_valid,
  input logic                 in_stall,
  input in_item_t             in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input out_item_t            out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // A singular result always ends the walk.
  a_sing_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |-> out_data.finished)
    else $error("singular result without finished");

  // An accepted column raises the rank and is never singular.
  a_acc_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> out_data.rank != '0 && !out_data.singular)
    else $error("accepted column with zero rank or singular");

  // An end of walk always produces a result, so the input is busy next cycle.
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.operation == OP_END |=> in_stall)
    else $error("end of walk item did not occupy the block");

endmodule

bind nonsingular_subset_lu_pivot nslu_chk u_nslu_chk (.*);
